// ===== sv/mts_pkg.sv =====
// ---------------------------------------------------------------------------
// mts_pkg - min tracking stack shared types
// Command and result payloads, operation and status codes.
// ---------------------------------------------------------------------------
package mts_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int DEPTH_WIDTH = 8;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic                          kind;
        logic signed [VALUE_WIDTH-1:0] value;
    } t_stack_cmd;

    typedef struct packed {
        logic [1:0]                    status;
        logic signed [VALUE_WIDTH-1:0] popped_value;
        logic signed [VALUE_WIDTH-1:0] min_value;
        logic                          min_valid;
        logic [DEPTH_WIDTH-1:0]        depth;
    } t_stack_rsp;

endpackage

// ===== sv/min_tracking_stack_unit.sv =====
// ---------------------------------------------------------------------------
// min_tracking_stack_unit - LIFO stack with running minimum
// Value stack and minimum stack in two synchronous RAMs, tops cached in flops.
// ---------------------------------------------------------------------------
//  channel   | signals                  | transfer
//  ----------+--------------------------+----------------------------------
//  command   | start, busy, i_cmd       | edge with start high, busy low
//  result    | o_valid, o_result        | every cycle o_valid is high
//
//  Push: result registered and shown in the cycle after the transfer; a push can be
//  taken every cycle while busy is low. Pop: busy high for one cycle; the result waits on
//  the RAM read of the entry under the top (value and minimum stacks read in parallel).
//  Synchronous reset empties both stacks; no clearing pass is needed.
//  The result side has no stall: each result is shown for one cycle only.
// ---------------------------------------------------------------------------
module min_tracking_stack_unit #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  mts_pkg::t_stack_cmd i_cmd,
    output logic                o_valid,
    output mts_pkg::t_stack_rsp o_result
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int VW = mts_pkg::VALUE_WIDTH;
    localparam int DW = mts_pkg::DEPTH_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_mcnt, n_mcnt;
    logic signed [VW-1:0]  r_vtop, n_vtop;
    logic signed [VW-1:0]  r_mtop, n_mtop;
    logic signed [VW-1:0]  r_pop_val, n_pop_val;
    logic                  r_pop_min, n_pop_min;
    logic                  r_out_valid, n_out_valid;
    mts_pkg::t_stack_rsp   r_out, n_out;

    logic signed [VW-1:0]  mem_val [STACK_DEPTH];
    logic signed [VW-1:0]  mem_min [STACK_DEPTH];
    logic signed [VW-1:0]  r_vrd, r_mrd;

    logic                  v_we, m_we;
    logic [AW-1:0]         v_waddr, m_waddr, v_raddr, m_raddr;
    logic signed [VW-1:0]  wdata;
    logic [CW-1:0]         cnt_m2, mcnt_m2;
    logic [CW+DW-1:0]      depth_ext;
    logic                  accept;

    assign accept  = start && (r_state == S_IDLE);
    assign busy    = (r_state == S_POP);
    assign cnt_m2  = r_cnt - CW'(2);
    assign mcnt_m2 = r_mcnt - CW'(2);
    assign v_raddr = cnt_m2[AW-1:0];
    assign m_raddr = mcnt_m2[AW-1:0];
    assign v_waddr = r_cnt[AW-1:0];
    assign m_waddr = r_mcnt[AW-1:0];
    assign wdata   = i_cmd.value;
    assign depth_ext = {{DW{1'b0}}, n_cnt};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_mcnt      = r_mcnt;
        n_vtop      = r_vtop;
        n_mtop      = r_mtop;
        n_pop_val   = r_pop_val;
        n_pop_min   = r_pop_min;
        n_out_valid = 1'b0;
        n_out       = r_out;
        v_we        = 1'b0;
        m_we        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.kind == mts_pkg::KIND_PUSH) begin
                        n_out_valid         = 1'b1;
                        n_out.popped_value  = '0;
                        if (r_cnt == CW'(STACK_DEPTH)) begin
                            n_out.status = mts_pkg::STATUS_OVERFLOW;
                        end else begin
                            n_out.status = mts_pkg::STATUS_OK;
                            v_we   = 1'b1;
                            n_vtop = i_cmd.value;
                            n_cnt  = r_cnt + CW'(1);
                            if ((r_mcnt != CW'(STACK_DEPTH)) &&
                                ((r_mcnt == '0) || (i_cmd.value <= r_mtop))) begin
                                m_we   = 1'b1;
                                n_mtop = i_cmd.value;
                                n_mcnt = r_mcnt + CW'(1);
                            end
                        end
                        n_out.min_valid = (n_cnt != '0) && (n_mcnt != '0);
                        n_out.min_value = n_out.min_valid ? n_mtop : '0;
                        n_out.depth     = depth_ext[DW-1:0];
                    end else if (r_cnt == '0) begin
                        n_out_valid        = 1'b1;
                        n_out.status       = mts_pkg::STATUS_UNDERFLOW;
                        n_out.popped_value = '0;
                        n_out.min_valid    = 1'b0;
                        n_out.min_value    = '0;
                        n_out.depth        = depth_ext[DW-1:0];
                    end else begin
                        // new tops come from the RAM read issued this cycle
                        n_state   = S_POP;
                        n_pop_val = r_vtop;
                        n_pop_min = (r_mcnt != '0) && (r_vtop == r_mtop);
                        n_cnt     = r_cnt - CW'(1);
                        if (n_pop_min) begin
                            n_mcnt = r_mcnt - CW'(1);
                        end
                    end
                end
            end
            S_POP: begin
                n_state            = S_IDLE;
                n_vtop             = r_vrd;
                if (r_pop_min) begin
                    n_mtop = r_mrd;
                end
                n_out_valid        = 1'b1;
                n_out.status       = mts_pkg::STATUS_OK;
                n_out.popped_value = r_pop_val;
                n_out.min_valid    = (r_cnt != '0) && (r_mcnt != '0);
                n_out.min_value    = n_out.min_valid ? n_mtop : '0;
                n_out.depth        = depth_ext[DW-1:0];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            mem_val[v_waddr] <= wdata;
        end
        r_vrd <= mem_val[v_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            mem_min[m_waddr] <= wdata;
        end
        r_mrd <= mem_min[m_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_mcnt      <= '0;
            r_pop_min   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_mcnt      <= n_mcnt;
            r_pop_min   <= n_pop_min;
            r_out_valid <= n_out_valid;
        end
        r_vtop    <= n_vtop;
        r_mtop    <= n_mtop;
        r_pop_val <= n_pop_val;
        r_out     <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== sv/mts_checker.sv =====
// ---------------------------------------------------------------------------
// mts_checker - port-level checks for min_tracking_stack_unit
// Watches command and result ports only; attached by bind.
// ---------------------------------------------------------------------------
module mts_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input mts_pkg::t_stack_cmd i_cmd,
    input logic                o_valid,
    input mts_pkg::t_stack_rsp o_result
);

    // busy only follows an accepted command, and lasts one cycle
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> $past(start && !busy))
        else $error("busy without a preceding command transfer");

    a_busy_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // every result comes from a transfer or the end of a pop
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) || $past(start && !busy)))
        else $error("result strobe with no command behind it");

    a_min_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.min_valid) |-> (o_result.min_value == '0))
        else $error("min_value nonzero while min_valid is low");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == mts_pkg::STATUS_UNDERFLOW)) |->
            (!o_result.min_valid && (o_result.popped_value == '0)))
        else $error("underflow result reports data");

endmodule

bind min_tracking_stack_unit mts_checker u_mts_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_valid  (o_valid),
    .o_result (o_result)
);
